// ----- src/sspan_pkg.sv -----
// Shared constants and request and result types for the stock span block.
package sspan_pkg;

	localparam int MAX_LEN_DEF = 1024;
	localparam int PRICE_BITS_DEF = 32;
	localparam int PRICE_W = 32;
	localparam int SPAN_W = 11;

	typedef struct packed {
		logic signed [PRICE_W-1:0] price;
		logic                      last;
	} sspan_item_t;

	typedef struct packed {
		logic [SPAN_W-1:0] span;
		logic              overflow;
	} sspan_result_t;

endpackage

// ----- src/sspan_queue.sv -----
// Two-entry command queue between the front and back parts.
module sspan_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	output logic         rd_valid,
	output logic [W-1:0] rd_data,
	input  logic         rd_en
);

	localparam int DEPTH = 2;
	localparam int AW = $clog2(DEPTH);

	logic [W-1:0]  entry_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;

	assign full = (count_q == (AW + 1)'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + (AW + 1)'(1);
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - (AW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ----- src/sspan_front.sv -----
// Front part: takes requests, forms the sort key, numbers the day and flags overflow.
module sspan_front import sspan_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF,
	parameter int PRICE_BITS = PRICE_BITS_DEF,
	localparam int IDX_W = $clog2(MAX_LEN),
	localparam int CMD_W = PRICE_BITS + IDX_W + 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  sspan_item_t      item,
	input  logic             q_full,
	output logic             q_wr,
	output logic [CMD_W-1:0] q_data
);

	localparam int POS_W = $clog2(MAX_LEN + 1);

	logic [POS_W-1:0]             day_pos_q;
	logic signed [PRICE_BITS-1:0] price_ext;
	logic [PRICE_BITS-1:0]        key;
	logic                         ovf;

	assign price_ext = PRICE_BITS'(item.price);
	assign key = {~price_ext[PRICE_BITS-1], price_ext[PRICE_BITS-2:0]};
	assign ovf = (day_pos_q == POS_W'(MAX_LEN));

	assign item_stall = q_full;
	assign q_wr = item_valid && !q_full;
	assign q_data = {key, day_pos_q[IDX_W-1:0], ovf, item.last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_pos_q <= '0;
		end else if (q_wr) begin
			if (item.last) begin
				day_pos_q <= '0;
			end else if (!ovf) begin
				day_pos_q <= day_pos_q + POS_W'(1);
			end
		end
	end

endmodule

// ----- src/sspan_back.sv -----
// Back part: monotonic stack in a memory, one pop per cycle, then span and push.
module sspan_back import sspan_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF,
	parameter int PRICE_BITS = PRICE_BITS_DEF,
	localparam int IDX_W = $clog2(MAX_LEN),
	localparam int CMD_W = PRICE_BITS + IDX_W + 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  logic [CMD_W-1:0] q_data,
	output logic             q_rd,
	output logic             result_valid,
	input  logic             result_stall,
	output sspan_result_t    result
);

	localparam int POS_W = $clog2(MAX_LEN + 1);
	localparam int ENT_W = IDX_W + PRICE_BITS;

	logic [ENT_W-1:0]      stack_mem [MAX_LEN];
	logic [ENT_W-1:0]      rd_q;
	logic [ENT_W-1:0]      top_q;
	logic                  use_mem_q;
	logic [POS_W-1:0]      level_q;
	logic                  out_valid_q;
	sspan_result_t         out_q;

	logic [PRICE_BITS-1:0] key;
	logic [IDX_W-1:0]      pos;
	logic                  ovf;
	logic                  last;
	logic [ENT_W-1:0]      top;
	logic [PRICE_BITS-1:0] top_key;
	logic [IDX_W-1:0]      top_pos;
	logic [POS_W-1:0]      lvl_m2;
	logic                  do_pop;
	logic                  finish;
	logic [IDX_W:0]        span_full;
	sspan_result_t         res;

	assign key = q_data[CMD_W-1 -: PRICE_BITS];
	assign pos = q_data[IDX_W+1:2];
	assign ovf = q_data[1];
	assign last = q_data[0];

	assign top = use_mem_q ? rd_q : top_q;
	assign top_pos = top[ENT_W-1 -: IDX_W];
	assign top_key = top[PRICE_BITS-1:0];
	assign lvl_m2 = level_q - POS_W'(2);

	assign do_pop = q_valid && !ovf && (level_q != '0) && (key > top_key);
	assign finish = q_valid && !do_pop && (!out_valid_q || !result_stall);
	assign q_rd = finish;

	always_comb begin
		if (level_q == '0) begin
			span_full = (IDX_W + 1)'({1'b0, pos}) + (IDX_W + 1)'(1);
		end else begin
			span_full = {1'b0, pos - top_pos};
		end
		if (ovf) begin
			res.span = '0;
			res.overflow = 1'b1;
		end else begin
			res.span = SPAN_W'(span_full);
			res.overflow = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			use_mem_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_pop) begin
				level_q <= level_q - POS_W'(1);
				use_mem_q <= 1'b1;
			end else if (finish) begin
				if (last) begin
					level_q <= '0;
				end else if (!ovf) begin
					level_q <= level_q + POS_W'(1);
				end
				if (!ovf) begin
					use_mem_q <= 1'b0;
				end
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			rd_q <= stack_mem[lvl_m2[IDX_W-1:0]];
		end
		if (finish && !ovf) begin
			stack_mem[level_q[IDX_W-1:0]] <= {pos, key};
			top_q <= {pos, key};
		end
		if (finish) begin
			out_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

endmodule

// ----- src/stock_span_monotonic_stack.sv -----
// An accepted request waits in the queue while the back part pops the entries it covers, then its
// result is registered and result_valid rises. The back part finishes one request before it takes
// the next, popping one entry per cycle from the single-port stack memory.
// A two-entry queue lets requests arrive while the back part pops or the result is held.
// Reset clears the day counter, stack level, queue and output valid; stack contents stay.
// Top level of the stock span block.
module stock_span_monotonic_stack import sspan_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF,
	parameter int PRICE_BITS = PRICE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  sspan_item_t   item,
	output logic          result_valid,
	input  logic          result_stall,
	output sspan_result_t result
);

	localparam int IDX_W = $clog2(MAX_LEN);
	localparam int CMD_W = PRICE_BITS + IDX_W + 2;

	logic             q_full;
	logic             q_wr;
	logic [CMD_W-1:0] q_wdata;
	logic             q_valid;
	logic [CMD_W-1:0] q_rdata;
	logic             q_rd;

	sspan_front #(
		.MAX_LEN(MAX_LEN),
		.PRICE_BITS(PRICE_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.q_full(q_full),
		.q_wr(q_wr),
		.q_data(q_wdata)
	);

	sspan_queue #(
		.W(CMD_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(q_wr),
		.wr_data(q_wdata),
		.full(q_full),
		.rd_valid(q_valid),
		.rd_data(q_rdata),
		.rd_en(q_rd)
	);

	sspan_back #(
		.MAX_LEN(MAX_LEN),
		.PRICE_BITS(PRICE_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_data(q_rdata),
		.q_rd(q_rd),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

endmodule

// ----- src/sspan_checker.sv -----
// Port checker for the stock span block and its binding.
module sspan_checker import sspan_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	input logic          item_valid,
	input logic          item_stall,
	input sspan_item_t   item,
	input logic          result_valid,
	input logic          result_stall,
	input sspan_result_t result
);

	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("Result request dropped while stalled.");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("Result payload changed while stalled.");

	a_overflow_span: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.overflow |-> result.span == '0)
		else $error("Overflow result carries a non-zero span.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(item_stall) |-> $past(item_valid && !item_stall))
		else $error("Input stall rose without a request having been taken.");

	a_item_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("Input request changed while stalled.");

endmodule

bind stock_span_monotonic_stack sspan_checker u_sspan_checker (.*);

// ----- verif/tb_top.sv -----
// Self-checking testbench for the stock span block with a driver, a monitor and a predictor.
module tb_top;
	import sspan_pkg::*;

	localparam int DEPTH = MAX_LEN_DEF;
	localparam int IDLE_PCT = 36;

	typedef struct {
		sspan_item_t req;
		bit          settle;
	} feed_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          item_valid = 1'b0;
	logic          item_stall;
	sspan_item_t   item = '0;
	logic          result_valid;
	logic          result_stall = 1'b0;
	sspan_result_t result;

	feed_t         feed_q[$];
	sspan_result_t span_expect[$];

	logic signed [PRICE_W-1:0] stack_price[DEPTH];
	int unsigned               stack_day[DEPTH];
	int unsigned               stack_level = 0;
	int unsigned               day_pos = 0;

	int errors = 0;
	int sent = 0;
	int results_seen = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	stock_span_monotonic_stack uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #1 clk = ~clk;

	task automatic flag_mismatch(input string what);
		$display("ERROR at %0t: %s", $realtime, what);
		errors++;
	endtask

	// Pops every entry with a strictly lower price, then pushes the new day.
	task automatic predict_span(input sspan_item_t req);
		sspan_result_t res;
		int unsigned   gap;
		res = '0;
		if (day_pos >= DEPTH) begin
			res.overflow = 1'b1;
		end else begin
			while (stack_level > 0 && $signed(req.price) > stack_price[stack_level - 1])
				stack_level--;
			gap = (stack_level == 0) ? day_pos + 1 : day_pos - stack_day[stack_level - 1];
			if (stack_level < DEPTH) begin
				stack_price[stack_level] = req.price;
				stack_day[stack_level] = day_pos;
				stack_level++;
			end
			day_pos++;
			res.span = gap[SPAN_W-1:0];
		end
		if (req.last) begin
			stack_level = 0;
			day_pos = 0;
		end
		span_expect.push_back(res);
	endtask

	task automatic add_day(input int p, input bit last, input bit settle);
		feed_t f;
		f.req.price = p;
		f.req.last = last;
		f.settle = settle;
		feed_q.push_back(f);
	endtask

	always @(posedge clk) begin
		feed_t nxt;
		bit    quiet;
		quiet = (sent >= 250 && sent < 400);
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
		end else if (!(item_valid && item_stall)) begin
			if (item_valid) begin
				predict_span(item);
				sent++;
			end
			if (feed_q.size() > 0 && !(feed_q[0].settle && span_expect.size() > 0) &&
			    (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
				nxt = feed_q.pop_front();
				item_valid <= 1'b1;
				item <= nxt.req;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		sspan_result_t want;
		bit            hold;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (span_expect.size() == 0) begin
					flag_mismatch($sformatf("result with nothing expected: span=%0d overflow=%0b",
						result.span, result.overflow));
				end else begin
					want = span_expect.pop_front();
					if (result.span !== want.span)
						flag_mismatch($sformatf("span %0d, expected %0d",
							result.span, want.span));
					if (result.overflow !== want.overflow)
						flag_mismatch($sformatf("overflow %0b, expected %0b",
							result.overflow, want.overflow));
				end
			end
			if (!hold_done && results_seen >= 120) begin
				hold_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				hold = 1'b1;
			end else if (results_seen >= 250 && results_seen < 400) begin
				hold = 1'b0;
			end else begin
				hold = ($urandom_range(0, 99) < IDLE_PCT);
			end
			result_stall <= hold;
		end
	end

	initial begin
		int n;
		int len;
		int mode;
		int p;
		int base;
		int total;

		// Equal prices, pops, both extremes and a single-day sequence.
		add_day(5, 1'b0, 1'b0);
		add_day(3, 1'b0, 1'b0);
		add_day(3, 1'b0, 1'b0);
		add_day(4, 1'b0, 1'b0);
		add_day(32'h7fffffff, 1'b0, 1'b0);
		add_day(32'h80000000, 1'b0, 1'b0);
		add_day(32'h7fffffff, 1'b0, 1'b0);
		add_day(-1, 1'b0, 1'b0);
		add_day(0, 1'b1, 1'b0);
		add_day(32'h80000000, 1'b1, 1'b0);
		add_day(-1, 1'b0, 1'b0);
		add_day(-1, 1'b0, 1'b0);
		add_day(0, 1'b0, 1'b0);
		add_day(32'h55555555, 1'b0, 1'b0);
		add_day(32'haaaaaaaa, 1'b0, 1'b0);
		add_day(32'h80000000, 1'b0, 1'b0);
		add_day(32'h80000000, 1'b0, 1'b0);
		add_day(32'h7fffffff, 1'b1, 1'b0);
		add_day(32'h7fffffff, 1'b0, 1'b1);
		add_day(32'h7ffffffe, 1'b0, 1'b0);
		add_day(32'h7fffffff, 1'b1, 1'b0);

		n = 0;
		while (n < 480) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
			mode = $urandom_range(0, 4);
			base = $urandom;
			for (int i = 0; i < len; i++) begin
				case (mode)
					0: p = $urandom;
					1: p = int'($urandom_range(0, 8)) - 4;
					2: p = base + i * 3 + int'($urandom_range(0, 6)) - 3;
					3: p = base - i * 3 + int'($urandom_range(0, 6)) - 3;
					default: begin
						case ($urandom_range(0, 3))
							0: p = 32'h80000000;
							1: p = 32'h7fffffff;
							2: p = -1;
							default: p = 0;
						endcase
					end
				endcase
				add_day(p, i == len - 1, (n == 300 && i == 0));
			end
			n += len;
		end

		// A deep stack emptied by one day.
		for (int i = 0; i < 100; i++)
			add_day(-i, 1'b0, i == 0);
		add_day(32'h7fffffff, 1'b1, 1'b0);
		add_day(1, 1'b0, 1'b0);
		add_day(1, 1'b1, 1'b0);

		total = feed_q.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (sent < total || span_expect.size() > 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
